@@ hdl/lpfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by every module of the block but the input stage.
package lpfd_pkg;

   localparam logic [7:0] SYNC_A_BYTE      = 8'hFF;
   localparam logic [7:0] SYNC_B_BYTE      = 8'hFE;
   localparam logic [7:0] END_MARK_BYTE    = 8'hF0;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd254;
   localparam logic [7:0] FRAME_LEN_RESET  = 8'd12;
   localparam int         KEEP_COUNT       = 12;
   localparam int         KEEP_IDX_W       = $clog2(KEEP_COUNT);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_SYNC = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [31:0] pos_x_bits;
      logic [31:0] pos_y_bits;
      logic [31:0] pos_z_bits;
      logic [7:0]  payload_len;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } result_type;

endpackage

@@ hdl/lpfd_in_stage.sv @@
// Input beat register for the deframer.
// No package dependencies; holds one received byte.
module lpfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       beat_valid,
   output logic [7:0] beat_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat_valid = valid_ff;
   assign beat_byte  = byte_ff;

endmodule

@@ hdl/lpfd_parser.sv @@
// Frame parser: phase machine, length and index counters, kept-byte store.
// Depends on lpfd_pkg for phase codes, marker bytes and the result struct.
module lpfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          beat_byte,
   input  logic [7:0]          max_length,
   output lpfd_pkg::result_type result
);

   lpfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] frame_len_ff, frame_len_in;
   logic [7:0] index_ff, index_in;
   logic [7:0] kept_ff [lpfd_pkg::KEEP_COUNT];
   logic [7:0] index_next;
   logic       keep_we;

   assign index_next = index_ff + 8'd1;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      index_in     = index_ff;
      if (fire) begin
         unique case (phase_ff)
            lpfd_pkg::PH_SYNC: begin
               phase_in = (beat_byte == lpfd_pkg::SYNC_B_BYTE) ?
                          lpfd_pkg::PH_LEN : lpfd_pkg::PH_HUNT;
            end
            lpfd_pkg::PH_LEN: begin
               frame_len_in = beat_byte;
               if (beat_byte > max_length) begin
                  phase_in = lpfd_pkg::PH_HUNT;
               end else begin
                  index_in = 8'd0;
                  phase_in = (beat_byte == 8'd0) ? lpfd_pkg::PH_END : lpfd_pkg::PH_DATA;
               end
            end
            lpfd_pkg::PH_DATA: begin
               index_in = index_next;
               if (index_next >= frame_len_ff) begin
                  phase_in = lpfd_pkg::PH_END;
               end
            end
            lpfd_pkg::PH_END: begin
               phase_in = lpfd_pkg::PH_HUNT;
            end
            default: begin
               phase_in = (beat_byte == lpfd_pkg::SYNC_A_BYTE) ?
                          lpfd_pkg::PH_SYNC : lpfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      keep_we = fire && (phase_ff == lpfd_pkg::PH_DATA) &&
                (index_ff < 8'(lpfd_pkg::KEEP_COUNT));
      result.valid = fire && (phase_ff == lpfd_pkg::PH_END) &&
                     (beat_byte == lpfd_pkg::END_MARK_BYTE);
      result.frame.pos_x_bits  = {kept_ff[3], kept_ff[2], kept_ff[1], kept_ff[0]};
      result.frame.pos_y_bits  = {kept_ff[7], kept_ff[6], kept_ff[5], kept_ff[4]};
      result.frame.pos_z_bits  = {kept_ff[11], kept_ff[10], kept_ff[9], kept_ff[8]};
      result.frame.payload_len = frame_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpfd_pkg::PH_HUNT;
         frame_len_ff <= lpfd_pkg::FRAME_LEN_RESET;
         index_ff     <= 8'd0;
         for (int i = 0; i < lpfd_pkg::KEEP_COUNT; i++) begin
            kept_ff[i] <= 8'd0;
         end
      end else begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         index_ff     <= index_in;
         if (keep_we) begin
            kept_ff[index_ff[lpfd_pkg::KEEP_IDX_W-1:0]] <= beat_byte;
         end
      end
   end

endmodule

@@ hdl/lpfd_out_stage.sv @@
// Result register for the deframer; holds one frame beat under stall.
// Depends on lpfd_pkg for the result and frame structs.
module lpfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  lpfd_pkg::result_type result,
   output logic                 open,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpfd_pkg::frame_type  frame
);

   logic                valid_ff, valid_in;
   lpfd_pkg::frame_type frame_ff, frame_in;

   assign open = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      if (open) begin
         valid_in = result.valid;
         if (result.valid) begin
            frame_in = result.frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      frame_ff <= frame_in;
   end

   assign rsp_valid = valid_ff;
   assign frame     = frame_ff;

endmodule

@@ hdl/length_prefixed_frame_deframer_top.sv @@
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_in_stage, lpfd_parser and lpfd_out_stage.
//
//  channel | ports            | beat
//  --------+------------------+---------------------------------------------
//  req     | req_valid/stall  | rx_byte
//  rsp     | rsp_valid/stall  | pos_x_bits, pos_y_bits, pos_z_bits, payload_len
//  csr     | csr_write_enable | max_length, write only
//
// One byte per cycle while the result is not stalled; a taken byte is held in the
// input register, and a result shows the cycle after its end byte is parsed.
// Reset is synchronous: hunting, max_length 254, kept bytes zero.
// A stalled result holds the parser; the input register still takes one byte.
module length_prefixed_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_x_bits,
   output logic [31:0] rsp_pos_y_bits,
   output logic [31:0] rsp_pos_z_bits,
   output logic [7:0]  rsp_payload_len,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]           max_len_ff, max_len_in;
   logic                 beat_valid;
   logic [7:0]           beat_byte;
   logic                 open;
   logic                 fire;
   lpfd_pkg::result_type result;
   lpfd_pkg::frame_type  frame;

   assign max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lpfd_pkg::MAX_LENGTH_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign fire = beat_valid && open;

   lpfd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (fire),
      .beat_valid  (beat_valid),
      .beat_byte   (beat_byte)
   );

   lpfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .beat_byte  (beat_byte),
      .max_length (max_len_ff),
      .result     (result)
   );

   lpfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .open      (open),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .frame     (frame)
   );

   assign rsp_pos_x_bits  = frame.pos_x_bits;
   assign rsp_pos_y_bits  = frame.pos_y_bits;
   assign rsp_pos_z_bits  = frame.pos_z_bits;
   assign rsp_payload_len = frame.payload_len;

endmodule

@@ hdl/lpfd_checker.sv @@
// Port-level checks for the deframer top level, attached by bind.
// Depends on the top level's port list and lpfd_pkg for the end marker.
module lpfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pos_x_bits,
   input logic [7:0]  rsp_payload_len
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x_bits) &&
                                 $stable(rsp_payload_len))
      else $error("stalled result beat changed");

   a_result_after_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && req_rx_byte == lpfd_pkg::END_MARK_BYTE, 2))
      else $error("result without an end byte two cycles before");

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_rx_byte     (req_rx_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pos_x_bits  (rsp_pos_x_bits),
   .rsp_payload_len (rsp_payload_len)
);
